@@ rtl/dpmd_pkg.sv @@
// Shared types, constants and the sequencer microcode for the deadband PID motor drive.
// Depends on nothing; used by dpmd_seq, dpmd_datapath and deadband_pid_motor_drive_top.
package dpmd_pkg;

    // Default parameter values
    localparam int VALUE_BITS_DEF     = 12;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Fixed field widths
    localparam int GAIN_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DUTY_W   = 7;
    localparam int PWM_W    = 8;
    localparam int MAG_W    = 12;

    // Scaling constants
    localparam int INTEGRAL_LIMIT = 2000;
    localparam int FULL_SCALE     = 2500;
    localparam int DUTY_MAX       = 100;
    localparam int PWM_MAX        = 255;

    // Reciprocal multipliers: /25 for mag < 2500, /100 for duty*255 <= 25500
    localparam int DIV25_MUL    = 2622;
    localparam int DIV25_SHIFT  = 16;
    localparam int DIV100_MUL   = 20972;
    localparam int DIV100_SHIFT = 21;
    localparam int PWM_X_W      = 15;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 3'd4;

    // Register reset values
    localparam int KP_RESET        = 256;
    localparam int KI_RESET        = 0;
    localparam int KD_RESET        = 0;
    localparam int BAND_HIGH_RESET = 600;
    localparam int BAND_LOW_RESET  = 400;

    typedef enum logic [1:0] {
        DIR_FWD   = 2'd0,
        DIR_REV   = 2'd1,
        DIR_BRAKE = 2'd2
    } dir_t;

    // Microcode word
    localparam int STEP_W = 4;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_WAIT_IN,
        COND_WAIT_OUT
    } cond_t;

    typedef enum logic [2:0] {
        A_ERR,
        A_DERR,
        A_MAG,
        A_DUTY,
        A_PROD
    } a_sel_t;

    typedef enum logic [2:0] {
        B_KP,
        B_KI,
        B_KD,
        B_DIV25,
        B_K255,
        B_DIV100
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_PROD,
        ACC_ADD_INT,
        ACC_ADD_PROD
    } acc_op_t;

    typedef struct packed {
        cond_t               cond;
        a_sel_t              a_sel;
        b_sel_t              b_sel;
        logic                mul_en;
        acc_op_t             acc_op;
        logic                err_en;
        logic                int_en;
        logic                prev_en;
        logic                mag_en;
        logic                duty_en;
        logic [STEP_W-1:0]   target;
    } ctrl_t;

    // Status from the handshake side into the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
    } seq_stat_t;

    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;

    // Control program, one word per step
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{cond: COND_NONE, a_sel: A_ERR, b_sel: B_KP, mul_en: 1'b0,
              acc_op: ACC_HOLD, err_en: 1'b0, int_en: 1'b0, prev_en: 1'b0,
              mag_en: 1'b0, duty_en: 1'b0, target: STEP_IDLE};
        case (step)
            4'd0:  w.cond = COND_WAIT_IN;            // wait for a measurement
            4'd1:  w.err_en = 1'b1;                  // deadband error
            4'd2:                                    // P product
            begin
                w.mul_en = 1'b1; w.a_sel = A_ERR; w.b_sel = B_KP;
            end
            4'd3:                                    // load P, I product
            begin
                w.acc_op = ACC_LOAD_PROD;
                w.mul_en = 1'b1; w.a_sel = A_ERR; w.b_sel = B_KI;
            end
            4'd4:                                    // update integral, D product
            begin
                w.int_en = 1'b1;
                w.mul_en = 1'b1; w.a_sel = A_DERR; w.b_sel = B_KD;
            end
            4'd5:                                    // add integral, save error
            begin
                w.acc_op = ACC_ADD_INT; w.prev_en = 1'b1;
            end
            4'd6:  w.acc_op = ACC_ADD_PROD;          // add D
            4'd7:  w.mag_en = 1'b1;                  // magnitude and direction
            4'd8:                                    // mag / 25
            begin
                w.mul_en = 1'b1; w.a_sel = A_MAG; w.b_sel = B_DIV25;
            end
            4'd9:  w.duty_en = 1'b1;                 // clamp duty
            4'd10:                                   // duty * 255
            begin
                w.mul_en = 1'b1; w.a_sel = A_DUTY; w.b_sel = B_K255;
            end
            4'd11:                                   // / 100
            begin
                w.mul_en = 1'b1; w.a_sel = A_PROD; w.b_sel = B_DIV100;
            end
            4'd12:                                   // hand off result
            begin
                w.cond = COND_WAIT_OUT; w.target = STEP_IDLE;
            end
            default: w.cond = COND_WAIT_OUT;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/dpmd_seq.sv @@
// Microcode sequencer: step counter and control-word lookup with conditional jumps.
// Depends on dpmd_pkg.
module dpmd_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  dpmd_pkg::seq_stat_t stat,
    output dpmd_pkg::ctrl_t    ctrl
);
    import dpmd_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // Fetch the word for the current step
    assign ctrl = ucode(step_reg);

    // Advance, hold on a wait condition, or jump
    always_comb
    begin
        step_next = step_reg + 1'b1;
        case (ctrl.cond)
            COND_WAIT_IN:  step_next = stat.in_valid ? step_reg + 1'b1 : step_reg;
            COND_WAIT_OUT: step_next = stat.out_free ? ctrl.target : step_reg;
            default:       step_next = step_reg + 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ rtl/dpmd_datapath.sv @@
// Datapath: configuration registers, shared multiplier, accumulator, PID state
// and the output register. Depends on dpmd_pkg; driven by dpmd_seq control words.
module dpmd_datapath #(
    parameter int VALUE_BITS     = dpmd_pkg::VALUE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = dpmd_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dpmd_pkg::ctrl_t                ctrl,
    input  logic                           in_accept,
    input  logic [VALUE_BITS-1:0]          meas,
    input  logic                           cfg_write,
    input  logic [dpmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dpmd_pkg::GAIN_W-1:0]    cfg_data,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic                           out_free,
    output logic [1:0]                     direction,
    output logic [dpmd_pkg::DUTY_W-1:0]    duty_percent,
    output logic [dpmd_pkg::PWM_W-1:0]     pwm_level,
    output logic                           drive_a,
    output logic                           drive_b
);
    import dpmd_pkg::*;

    localparam int ERR_W  = VALUE_BITS + 1;
    localparam int DERR_W = VALUE_BITS + 2;
    localparam int A_W    = (DERR_W > GAIN_W) ? DERR_W : GAIN_W;
    localparam int PROD_W = A_W + GAIN_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int INT_W  = 12 + GAIN_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] LIMIT =
        SUM_W'(INTEGRAL_LIMIT) <<< GAIN_FRAC_BITS;

    // Configuration registers
    logic [GAIN_W-1:0]     kp_reg, ki_reg, kd_reg;
    logic [VALUE_BITS-1:0] band_high_reg, band_low_reg;

    // Working registers
    logic [VALUE_BITS-1:0]    meas_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  prev_reg;
    logic signed [INT_W-1:0]  integral_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     sat_reg;
    dir_t                     dir_reg;
    logic [DUTY_W-1:0]        duty_reg;

    // Output register
    logic              out_valid_reg;
    dir_t              out_dir_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic [PWM_W-1:0]  out_pwm_reg;

    logic signed [ERR_W-1:0]  err_next;
    logic signed [DERR_W-1:0] derr;
    logic signed [A_W-1:0]    a_op;
    logic [GAIN_W-1:0]        b_op;
    logic signed [PROD_W-1:0] mul;
    logic signed [SUM_W-1:0]  int_sum;
    logic signed [SUM_W-1:0]  mag_abs;
    logic signed [SUM_W-1:0]  mag_shift;
    logic                     out_load;

    // Deadband error: upper edge tested first
    always_comb
    begin
        if (meas_reg > band_high_reg)
        begin
            err_next = $signed({1'b0, meas_reg}) - $signed({1'b0, band_high_reg});
        end
        else if (meas_reg < band_low_reg)
        begin
            err_next = $signed({1'b0, meas_reg}) - $signed({1'b0, band_low_reg});
        end
        else
        begin
            err_next = '0;
        end
    end

    assign derr = DERR_W'(err_reg) - DERR_W'(prev_reg);

    // Multiplier operand selection
    always_comb
    begin
        case (ctrl.a_sel)
            A_ERR:   a_op = A_W'(err_reg);
            A_DERR:  a_op = A_W'(derr);
            A_MAG:   a_op = A_W'($signed({1'b0, mag_reg}));
            A_DUTY:  a_op = A_W'($signed({1'b0, duty_reg}));
            A_PROD:  a_op = A_W'($signed({1'b0, prod_reg[PWM_X_W-1:0]}));
            default: a_op = '0;
        endcase
        case (ctrl.b_sel)
            B_KP:     b_op = kp_reg;
            B_KI:     b_op = ki_reg;
            B_KD:     b_op = kd_reg;
            B_DIV25:  b_op = GAIN_W'(DIV25_MUL);
            B_K255:   b_op = GAIN_W'(PWM_MAX);
            B_DIV100: b_op = GAIN_W'(DIV100_MUL);
            default:  b_op = '0;
        endcase
    end

    assign mul = a_op * $signed({1'b0, b_op});

    // Integral update with clear on overrun
    assign int_sum = SUM_W'(integral_reg) + SUM_W'(prod_reg);

    // Magnitude of the integer part, truncated toward zero
    assign mag_abs   = (acc_reg < 0) ? -acc_reg : acc_reg;
    assign mag_shift = mag_abs >>> GAIN_FRAC_BITS;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (ctrl.cond == COND_WAIT_OUT) && out_free;
    assign out_valid = out_valid_reg;

    assign direction    = out_dir_reg;
    assign duty_percent = out_duty_reg;
    assign pwm_level    = out_pwm_reg;
    assign drive_a      = (out_dir_reg != DIR_REV);
    assign drive_b      = (out_dir_reg != DIR_FWD);

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= GAIN_W'(KP_RESET);
            ki_reg        <= GAIN_W'(KI_RESET);
            kd_reg        <= GAIN_W'(KD_RESET);
            band_high_reg <= VALUE_BITS'(BAND_HIGH_RESET);
            band_low_reg  <= VALUE_BITS'(BAND_LOW_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KP:        kp_reg        <= cfg_data;
                REG_KI:        ki_reg        <= cfg_data;
                REG_KD:        kd_reg        <= cfg_data;
                REG_BAND_HIGH: band_high_reg <= cfg_data[VALUE_BITS-1:0];
                REG_BAND_LOW:  band_low_reg  <= cfg_data[VALUE_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // Controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_reg     <= '0;
        end
        else
        begin
            if (ctrl.int_en)
            begin
                if (int_sum > LIMIT || int_sum < -LIMIT)
                begin
                    integral_reg <= '0;
                end
                else
                begin
                    integral_reg <= INT_W'(int_sum);
                end
            end
            if (ctrl.prev_en)
            begin
                prev_reg <= err_reg;
            end
        end
    end

    // Working registers under microcode control
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            meas_reg <= meas;
        end
        if (ctrl.err_en)
        begin
            err_reg <= err_next;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= mul;
        end
        case (ctrl.acc_op)
            ACC_LOAD_PROD: acc_reg <= SUM_W'(prod_reg);
            ACC_ADD_INT:   acc_reg <= acc_reg + SUM_W'(integral_reg);
            ACC_ADD_PROD:  acc_reg <= acc_reg + SUM_W'(prod_reg);
            default:       acc_reg <= acc_reg;
        endcase
        if (ctrl.mag_en)
        begin
            sat_reg <= (mag_shift >= SUM_W'(FULL_SCALE));
            mag_reg <= mag_shift[MAG_W-1:0];
            if (acc_reg > 0)
            begin
                dir_reg <= DIR_FWD;
            end
            else if (acc_reg < 0)
            begin
                dir_reg <= DIR_REV;
            end
            else
            begin
                dir_reg <= DIR_BRAKE;
            end
        end
        if (ctrl.duty_en)
        begin
            duty_reg <= sat_reg ? DUTY_W'(DUTY_MAX) : prod_reg[DIV25_SHIFT +: DUTY_W];
        end
    end

    // Output register: hold until transfer, reload from the last step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_dir_reg  <= dir_reg;
            out_duty_reg <= duty_reg;
            out_pwm_reg  <= prod_reg[DIV100_SHIFT +: PWM_W];
        end
    end

endmodule

@@ rtl/deadband_pid_motor_drive_top.sv @@
// Deadband PID motor drive, top level. Depends on dpmd_pkg, dpmd_seq and dpmd_datapath.
// The 13-step microcode program, idle step included, shares one multiplier, waits in its
// last step while the result is stalled, and takes the next input only after the hand-off.
// Reset (rst_n low, asynchronous) clears the integral, previous error, sequencer and
// output valid, and loads the configuration registers with their defaults.
module deadband_pid_motor_drive_top #(
    parameter int VALUE_BITS     = dpmd_pkg::VALUE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = dpmd_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,   // measured_value
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // direction[1:0],
                                                           // duty_percent[8:2],
                                                           // pwm_level[16:9],
                                                           // drive_a[17], drive_b[18]
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dpmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpmd_pkg::GAIN_W-1:0]         cfg_data
);
    import dpmd_pkg::*;

    localparam int OUT_USED = 2 + DUTY_W + PWM_W + 2;

    ctrl_t             ctrl;
    seq_stat_t         stat;
    logic              out_free;
    logic              in_accept;
    logic [1:0]        direction;
    logic [DUTY_W-1:0] duty_percent;
    logic [PWM_W-1:0]  pwm_level;
    logic              drive_a;
    logic              drive_b;

    // Accept input only in the idle step
    assign s_tready  = (ctrl.cond == COND_WAIT_IN);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign stat.in_valid = s_tvalid;
    assign stat.out_free = out_free;

    dpmd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    dpmd_datapath #(
        .VALUE_BITS     (VALUE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .in_accept    (in_accept),
        .meas         (s_tdata[VALUE_BITS-1:0]),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_free     (out_free),
        .direction    (direction),
        .duty_percent (duty_percent),
        .pwm_level    (pwm_level),
        .drive_a      (drive_a),
        .drive_b      (drive_b)
    );

    // Pack the result fields, lowest first
    assign m_tdata = {{(24-OUT_USED){1'b0}}, drive_b, drive_a, pwm_level,
                      duty_percent, direction};

endmodule
